/* rtl/grid_dda_raycast_core_defines.svh */
// shared assertion macros for the raycaster
`ifndef GRID_DDA_RAYCAST_CORE_DEFINES_SVH
`define GRID_DDA_RAYCAST_CORE_DEFINES_SVH

// condition holds in the same cycle
`define GDR_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define GDR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/gdr_pkg.sv */
package gdr_pkg;

    localparam int MAP_SIDE_DEF    = 64;
    localparam int ANGLE_STEPS_DEF = 1024;
    localparam int HEAD_N          = 1024;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint ONE_Q30     = 64'sd1073741824;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef enum logic [1:0] {
        CFG_PLANE_LENGTH,
        CFG_SCREEN_WIDTH,
        CFG_MAP_WIDTH,
        CFG_MAP_HEIGHT
    } cfg_index_t;

    localparam logic [15:0] PLANE_LENGTH_RST = 16'd16384;
    localparam logic [10:0] SCREEN_WIDTH_RST = 11'd320;
    localparam logic [6:0]  MAP_WIDTH_RST    = 7'd64;
    localparam logic [6:0]  MAP_HEIGHT_RST   = 7'd64;

    // shared divider widths
    localparam int DIV_NW = 31;
    localparam int DIV_DW = 29;
    localparam int DIV_CW = 5;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // taylor sine of a q30 angle in the first quadrant, q14 result
    function automatic int sin_q14(longint x);
        longint x2;
        longint term;
        longint sum;
        x2   = (x * x) >>> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >>> 30) / 6;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 20;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 42;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 72;
        sum  = sum + term;
        term = ((term * x2) >>> 30) / 110;
        sum  = sum - term;
        term = ((term * x2) >>> 30) / 156;
        sum  = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        if (sum > ONE_Q30)
        begin
            sum = ONE_Q30;
        end
        return int'((sum + 64'sd32768) >>> 16);
    endfunction

endpackage

/* rtl/gdr_cast_if.sv */
interface gdr_cast_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [5:0]  cell_x;
    logic [5:0]  cell_y;
    logic        cell_wall;
    logic [15:0] player_x;
    logic [15:0] player_y;
    logic [9:0]  heading;
    logic [9:0]  column;

    modport source (
        output valid, operation, cell_x, cell_y, cell_wall,
               player_x, player_y, heading, column,
        input  ready
    );
    modport sink (
        input  valid, operation, cell_x, cell_y, cell_wall,
               player_x, player_y, heading, column,
        output ready
    );
endinterface

/* rtl/gdr_result_if.sv */
interface gdr_result_if;
    logic              valid;
    logic              ready;
    logic              hit;
    logic [15:0]       distance;
    logic signed [7:0] hit_x;
    logic signed [7:0] hit_y;
    logic              vertical_wall;

    modport source (
        output valid, hit, distance, hit_x, hit_y, vertical_wall,
        input  ready
    );
    modport sink (
        input  valid, hit, distance, hit_x, hit_y, vertical_wall,
        output ready
    );
endinterface

/* rtl/gdr_div.sv */
`include "grid_dda_raycast_core_defines.svh"

module gdr_div
    import gdr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic [DIV_NW-1:0] quotient,
    output div_status_t       status
);

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;

    logic [DIV_DW:0]   rem_sh;
    logic              q_bit;
    logic [DIV_DW-1:0] rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        rem_sh   = {rem_reg, quo_reg[DIV_NW-1]};
        q_bit    = (rem_sh >= {1'b0, den_reg});
        rem_next = q_bit ? DIV_DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            den_reg  <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == DIV_CW'(DIV_NW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                den_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DIV_NW-2:0], q_bit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    `GDR_ASSERT_NOW(a_start_idle, start, !busy_reg, "divider started while busy")
    `GDR_ASSERT_NEXT(a_start_busy, start, busy_reg, "divider did not go busy")
    `GDR_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "divider done while busy")

endmodule

/* rtl/grid_dda_raycast_core.sv */
// grid ray caster: a wall grid of one bit per cell and a dda walker.
// cast_in takes items of two kinds. a write item (operation 0) sets one cell
// and gives no result. a cast item (operation 1) builds a ray for one
// screen column and walks the grid; it gives one item on result_out: hit
// flag, q8.8 perpendicular distance, hit cell and wall side.
// cfg_we/cfg_index/cfg_data write plane_length, screen_width, map_width and
// map_height; write them only while the block is idle.
// a cast first sets up the ray with the shared bit-serial divider, run up to
// three times (camera offset and the two step distances), then walks the
// grid cell by cell, each cell with one grid memory read and one wall check.
// one item is in work at a time.
// after reset the grid memory is cleared one cell per cycle, all MAP_SIDE *
// MAP_SIDE cells (4096 by default); cast_in.ready stays low meanwhile.
// the result sits in an output register; the next item is taken while it
// waits, and a finished cast holds until that register is free.
`include "grid_dda_raycast_core_defines.svh"

module grid_dda_raycast_core
    import gdr_pkg::*;
#(
    parameter int MAP_SIDE    = MAP_SIDE_DEF,
    parameter int ANGLE_STEPS = ANGLE_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    gdr_cast_if.sink    cast_in,
    gdr_result_if.source result_out
);

    localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int CW        = $clog2(MAP_DEPTH + 2);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_PLX, S_PLY, S_CAM_GO, S_CAM_W, S_RX, S_RY,
        S_DX_GO, S_DX_W, S_DY_GO, S_DY_W, S_SX, S_SY, S_STEP, S_CHECK,
        S_DONE
    } state_t;

    // fix enum width for seventeen states
    state_t state_reg;

    logic [15:0] plane_length_reg;
    logic [10:0] screen_width_reg;
    logic [6:0]  map_width_reg;
    logic [6:0]  map_height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_length_reg <= PLANE_LENGTH_RST;
            screen_width_reg <= SCREEN_WIDTH_RST;
            map_width_reg    <= MAP_WIDTH_RST;
            map_height_reg   <= MAP_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PLANE_LENGTH: plane_length_reg <= cfg_data;
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data[10:0];
                CFG_MAP_WIDTH:    map_width_reg    <= cfg_data[6:0];
                CFG_MAP_HEIGHT:   map_height_reg   <= cfg_data[6:0];
                default:          plane_length_reg <= plane_length_reg;
            endcase
        end
    end

    // sine/cosine rom, one entry per heading code, built at elaboration
    logic [31:0] trig_lut [HEAD_N];
    logic [31:0] trig_q;

    for (genvar gi = 0; gi < HEAD_N; gi++)
    begin : g_trig
        localparam int     T  = (gi % ANGLE_STEPS) * 4;
        localparam int     QS = (T / ANGLE_STEPS) % 4;
        localparam int     QC = (QS + 1) % 4;
        localparam longint XB = (longint'(T % ANGLE_STEPS) * HALF_PI_Q30) / ANGLE_STEPS;
        localparam longint XS = (QS % 2 == 1) ? HALF_PI_Q30 - XB : XB;
        localparam longint XC = (QC % 2 == 1) ? HALF_PI_Q30 - XB : XB;
        localparam int     VS = sin_q14(XS);
        localparam int     VC = sin_q14(XC);
        localparam int     SS = (QS >= 2) ? -VS : VS;
        localparam int     SC = (QC >= 2) ? -VC : VC;
        assign trig_lut[gi] = {16'(SS), 16'(SC)};
    end

    always_ff @(posedge clk)
    begin
        trig_q <= trig_lut[cast_in.heading];
    end

    // grid memory
    logic wall_mem [MAP_DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic          mem_rdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            wall_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata <= wall_mem[mem_raddr];
    end

    // datapath registers
    logic [AW-1:0]      clr_cnt_reg;
    logic [15:0]        px_reg;
    logic [15:0]        py_reg;
    logic [9:0]         col_reg;
    logic [CW-1:0]      limit_reg;
    logic [CW-1:0]      cnt_reg;
    logic signed [15:0] s_reg;
    logic signed [15:0] c_reg;
    logic signed [17:0] plane_x_reg;
    logic signed [17:0] plane_y_reg;
    logic signed [26:0] cam_reg;
    logic signed [28:0] rx_reg;
    logic signed [28:0] ry_reg;
    logic [40:0]        dx_reg;
    logic [40:0]        dy_reg;
    logic [55:0]        sx_reg;
    logic [55:0]        sy_reg;
    logic [55:0]        dist_reg;
    logic signed [8:0]  mx_reg;
    logic signed [8:0]  my_reg;
    logic               vert_reg;

    logic               out_valid_reg;
    logic               res_hit_reg;
    logic [15:0]        res_dist_reg;
    logic [7:0]         res_x_reg;
    logic [7:0]         res_y_reg;
    logic               res_vert_reg;
    logic               out_hit_reg;
    logic [15:0]        out_dist_reg;
    logic [7:0]         out_x_reg;
    logic [7:0]         out_y_reg;
    logic               out_vert_reg;

    logic in_fire;
    logic out_fire;
    assign cast_in.ready = (state_reg == S_IDLE);
    assign in_fire       = cast_in.valid && cast_in.ready;
    assign out_fire      = out_valid_reg && result_out.ready;

    logic [6:0]  w_eff;
    logic [6:0]  h_eff;
    logic [10:0] sw_eff;
    logic        wr_in_range;
    assign w_eff  = (int'(map_width_reg) > MAP_SIDE) ? 7'(MAP_SIDE) : map_width_reg;
    assign h_eff  = (int'(map_height_reg) > MAP_SIDE) ? 7'(MAP_SIDE) : map_height_reg;
    assign sw_eff = (screen_width_reg == 11'd0) ? 11'd1 : screen_width_reg;
    assign wr_in_range = (int'(cast_in.cell_x) < MAP_SIDE) && (int'(cast_in.cell_y) < MAP_SIDE);

    // plane multiplier: cos or -sin times plane_length
    logic signed [16:0] pl_op;
    logic signed [32:0] pl_prod;
    assign pl_op   = (state_reg == S_PLX) ? 17'($signed(trig_q[15:0]))
                                          : -17'(s_reg);
    assign pl_prod = 33'(pl_op) * $signed({17'd0, plane_length_reg});

    // ray multiplier: plane times camera offset
    logic signed [17:0] ray_plane;
    logic signed [44:0] ray_prod;
    logic signed [28:0] ray_sum;
    assign ray_plane = (state_reg == S_RX) ? plane_x_reg : plane_y_reg;
    assign ray_prod  = 45'(ray_plane) * 45'(cam_reg);
    assign ray_sum   = ((state_reg == S_RX) ? 29'(s_reg) : 29'(c_reg)) + ray_prod[42:14];

    // divider hookup
    logic              div_start;
    logic [DIV_NW-1:0] div_num;
    logic [DIV_DW-1:0] div_den;
    logic [DIV_NW-1:0] div_quo;
    div_status_t       div_st;
    logic [28:0]       rx_abs;
    logic [28:0]       ry_abs;
    assign rx_abs = rx_reg[28] ? 29'(-rx_reg) : 29'(rx_reg);
    assign ry_abs = ry_reg[28] ? 29'(-ry_reg) : 29'(ry_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = DIV_NW'(ONE_Q30);
        div_den   = rx_abs;
        case (state_reg)
            S_CAM_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'({col_reg, 1'b1, 14'd0});
                div_den   = DIV_DW'(sw_eff);
            end
            S_DX_GO:
            begin
                div_start = (rx_reg != '0);
            end
            S_DY_GO:
            begin
                div_start = (ry_reg != '0);
                div_den   = ry_abs;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    gdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .status   (div_st)
    );

    // first side distance
    logic [10:0] frac_x;
    logic [10:0] frac_y;
    logic [10:0] frac_sel;
    logic [30:0] dq_sel;
    logic        sat_sel;
    logic [41:0] side_prod;
    logic [55:0] side_val;
    assign frac_x   = rx_reg[28] ? {1'b0, px_reg[9:0]} : 11'd1024 - {1'b0, px_reg[9:0]};
    assign frac_y   = ry_reg[28] ? {1'b0, py_reg[9:0]} : 11'd1024 - {1'b0, py_reg[9:0]};
    assign frac_sel = (state_reg == S_SX) ? frac_x : frac_y;
    assign dq_sel   = (state_reg == S_SX) ? dx_reg[30:0] : dy_reg[30:0];
    assign sat_sel  = (state_reg == S_SX) ? dx_reg[40] : dy_reg[40];
    assign side_prod = 42'(frac_sel) * 42'(dq_sel);
    assign side_val  = sat_sel ? 56'({frac_sel, 30'd0}) : 56'(side_prod[41:10]);

    // walk step
    logic              take_x;
    logic signed [8:0] nx;
    logic signed [8:0] ny;
    logic              outside;
    logic [47:0]       dist_q;
    logic [15:0]       dist_sat;
    assign take_x = (sx_reg < sy_reg);
    assign nx = take_x ? (rx_reg[28] ? mx_reg - 9'sd1 : mx_reg + 9'sd1) : mx_reg;
    assign ny = take_x ? my_reg : (ry_reg[28] ? my_reg - 9'sd1 : my_reg + 9'sd1);
    assign outside = (mx_reg < 9'sd0) || (my_reg < 9'sd0)
                  || (mx_reg >= $signed({2'b00, w_eff}))
                  || (my_reg >= $signed({2'b00, h_eff}));
    assign dist_q   = dist_reg[55:8];
    assign dist_sat = (dist_q == '0) ? 16'd1
                    : (dist_q > 48'd65535) ? 16'hFFFF : dist_q[15:0];

    always_comb
    begin
        mem_raddr = AW'(int'(ny) * MAP_SIDE + int'(nx));
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
            mem_wdata = 1'b0;
        end
        else
        begin
            mem_we    = in_fire && (cast_in.operation == OP_WRITE) && wr_in_range;
            mem_waddr = AW'(int'(cast_in.cell_y) * MAP_SIDE + int'(cast_in.cell_x));
            mem_wdata = cast_in.cell_wall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            px_reg        <= '0;
            py_reg        <= '0;
            col_reg       <= '0;
            limit_reg     <= '0;
            cnt_reg       <= '0;
            s_reg         <= '0;
            c_reg         <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= '0;
            cam_reg       <= '0;
            rx_reg        <= '0;
            ry_reg        <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            dist_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            vert_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            res_hit_reg   <= 1'b0;
            res_dist_reg  <= '0;
            res_x_reg     <= '0;
            res_y_reg     <= '0;
            res_vert_reg  <= 1'b0;
            out_hit_reg   <= 1'b0;
            out_dist_reg  <= '0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_vert_reg  <= 1'b0;
        end
        else
        begin
            // in S_DONE the output register is reloaded below instead
            if (out_fire && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(MAP_DEPTH - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire && (cast_in.operation == OP_CAST))
                    begin
                        px_reg    <= cast_in.player_x;
                        py_reg    <= cast_in.player_y;
                        col_reg   <= cast_in.column;
                        limit_reg <= CW'(int'(w_eff) * int'(h_eff) + 1);
                        state_reg <= S_PLX;
                    end
                end
                S_PLX:
                begin
                    s_reg       <= $signed(trig_q[31:16]);
                    c_reg       <= $signed(trig_q[15:0]);
                    plane_x_reg <= pl_prod[31:14];
                    state_reg   <= S_PLY;
                end
                S_PLY:
                begin
                    plane_y_reg <= pl_prod[31:14];
                    state_reg   <= S_CAM_GO;
                end
                S_CAM_GO:
                begin
                    state_reg <= S_CAM_W;
                end
                S_CAM_W:
                begin
                    if (div_st.done)
                    begin
                        cam_reg   <= $signed({1'b0, div_quo[25:0]}) - 27'sd16384;
                        state_reg <= S_RX;
                    end
                end
                S_RX:
                begin
                    rx_reg    <= ray_sum;
                    state_reg <= S_RY;
                end
                S_RY:
                begin
                    ry_reg    <= ray_sum;
                    state_reg <= S_DX_GO;
                end
                S_DX_GO:
                begin
                    if (rx_reg == '0)
                    begin
                        // parallel to the axis: saturated step
                        dx_reg    <= 41'd1 << 40;
                        state_reg <= S_DY_GO;
                    end
                    else
                    begin
                        state_reg <= S_DX_W;
                    end
                end
                S_DX_W:
                begin
                    if (div_st.done)
                    begin
                        dx_reg    <= 41'(div_quo);
                        state_reg <= S_DY_GO;
                    end
                end
                S_DY_GO:
                begin
                    if (ry_reg == '0)
                    begin
                        dy_reg    <= 41'd1 << 40;
                        state_reg <= S_SX;
                    end
                    else
                    begin
                        state_reg <= S_DY_W;
                    end
                end
                S_DY_W:
                begin
                    if (div_st.done)
                    begin
                        dy_reg    <= 41'(div_quo);
                        state_reg <= S_SX;
                    end
                end
                S_SX:
                begin
                    sx_reg    <= side_val;
                    state_reg <= S_SY;
                end
                S_SY:
                begin
                    sy_reg    <= side_val;
                    mx_reg    <= $signed({3'b000, px_reg[15:10]});
                    my_reg    <= $signed({3'b000, py_reg[15:10]});
                    cnt_reg   <= '0;
                    state_reg <= S_STEP;
                end
                S_STEP:
                begin
                    if (cnt_reg == limit_reg)
                    begin
                        // step limit reached, no wall
                        res_hit_reg  <= 1'b0;
                        res_dist_reg <= '0;
                        res_x_reg    <= '0;
                        res_y_reg    <= '0;
                        res_vert_reg <= 1'b0;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        if (take_x)
                        begin
                            dist_reg <= sx_reg;
                            sx_reg   <= sx_reg + 56'(dx_reg);
                        end
                        else
                        begin
                            dist_reg <= sy_reg;
                            sy_reg   <= sy_reg + 56'(dy_reg);
                        end
                        mx_reg    <= nx;
                        my_reg    <= ny;
                        vert_reg  <= take_x;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (outside || mem_rdata)
                    begin
                        res_hit_reg  <= 1'b1;
                        res_dist_reg <= dist_sat;
                        res_x_reg    <= mx_reg[7:0];
                        res_y_reg    <= my_reg[7:0];
                        res_vert_reg <= vert_reg;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_STEP;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result_out.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_hit_reg   <= res_hit_reg;
                        out_dist_reg  <= res_dist_reg;
                        out_x_reg     <= res_x_reg;
                        out_y_reg     <= res_y_reg;
                        out_vert_reg  <= res_vert_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.hit           = out_hit_reg;
    assign result_out.distance      = out_dist_reg;
    assign result_out.hit_x         = $signed(out_x_reg);
    assign result_out.hit_y         = $signed(out_y_reg);
    assign result_out.vertical_wall = out_vert_reg;

    `GDR_ASSERT_NOW(a_clear_blocks, state_reg == S_CLEAR, !cast_in.ready,
        "item taken during grid clear")
    `GDR_ASSERT_NOW(a_write_when_idle, mem_we,
        (state_reg == S_CLEAR) || (state_reg == S_IDLE), "grid written during a cast")
    `GDR_ASSERT_NOW(a_walk_bound, state_reg == S_CHECK, cnt_reg < limit_reg,
        "walk ran past the step limit")
    `GDR_ASSERT_NOW(a_div_done_wait, div_st.done,
        (state_reg == S_CAM_W) || (state_reg == S_DX_W) || (state_reg == S_DY_W),
        "divider finished outside a wait state")

endmodule

/* bench/gdr_tb_if.sv */
`timescale 1ns / 100ps
// channel interfaces are compiled from rtl; this file holds only the ray_hit_t result type
package gdr_tb_types;
    typedef struct packed {
        logic              hit;
        logic [15:0]       distance;
        logic signed [7:0] hit_x;
        logic signed [7:0] hit_y;
        logic              vertical_wall;
    } ray_hit_t;
endpackage

/* bench/grid_dda_raycast_core_tb.sv */
`timescale 1ns / 100ps
module grid_dda_raycast_core_tb;
    import gdr_pkg::*;
    import gdr_tb_types::*;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [15:0] cfg_data;

    gdr_cast_if cast_ch ();
    gdr_result_if res_ch ();

    grid_dda_raycast_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cast_in(cast_ch.sink), .result_out(res_ch.source)
    );

    // predictor state
    bit          grid [0:4095];
    logic [15:0] m_plane;
    logic [10:0] m_screen;
    logic [6:0]  m_mapw;
    logic [6:0]  m_maph;

    ray_hit_t pending_hits [$];
    int mismatches;
    int casts_checked;
    int idle_cycles;
    bit hold_off;
    bit sink_calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint fdiv_pow2(longint v, int n);
        if (v >= 0)
            return v >>> n;
        return -((-v - 1) >>> n) - 1;
    endfunction

    function automatic longint quarter_sine(longint x);
        longint x2, term, sum;
        x2 = (x * x) >>> 30;
        term = x;
        sum = x;
        for (int k = 1; k <= 6; k++)
        begin
            term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
            sum = (k % 2 == 1) ? sum - term : sum + term;
        end
        if (sum < 0)
            sum = 0;
        if (sum > ONE_Q30)
            sum = ONE_Q30;
        return (sum + 32768) >>> 16;
    endfunction

    function automatic longint heading_trig(int h, int shift);
        longint t, x, v;
        int q;
        t = longint'(h % 1024) * 4;
        q = int'((t / 1024 + shift) % 4);
        x = (t % 1024) * HALF_PI_Q30 / 1024;
        if (q % 2 == 1)
            x = HALF_PI_Q30 - x;
        v = quarter_sine(x);
        return (q >= 2) ? -v : v;
    endfunction

    function automatic bit blocked(longint x, longint y, longint w, longint h);
        if (x < 0 || y < 0 || x >= w || y >= h)
            return 1'b1;
        return grid[y * 64 + x];
    endfunction

    function automatic ray_hit_t cast_ray(logic [15:0] px, logic [15:0] py,
                                          logic [9:0] hd, logic [9:0] col);
        ray_hit_t r;
        longint s, c, sw, cam, rx, ry, dx, dy, mx, my, stx, sty, sx, sy;
        longint w, h, lim, wall_span;
        bit vert;
        r = '0;
        vert = 1'b0;
        s = heading_trig(hd, 0);
        c = heading_trig(hd, 1);
        sw = (m_screen == 0) ? 1 : m_screen;
        cam = ((2 * longint'(col) + 1) <<< 14) / sw - 16384;
        rx = s + fdiv_pow2(fdiv_pow2(c * m_plane, 14) * cam, 14);
        ry = c + fdiv_pow2(fdiv_pow2(-s * m_plane, 14) * cam, 14);
        dx = (rx == 0) ? (64'sd1 <<< 40) : ONE_Q30 / (rx < 0 ? -rx : rx);
        dy = (ry == 0) ? (64'sd1 <<< 40) : ONE_Q30 / (ry < 0 ? -ry : ry);
        mx = px >> 10;
        my = py >> 10;
        stx = rx < 0 ? -1 : 1;
        sty = ry < 0 ? -1 : 1;
        sx = ((rx < 0 ? longint'(px[9:0]) : 1024 - longint'(px[9:0])) * dx) >>> 10;
        sy = ((ry < 0 ? longint'(py[9:0]) : 1024 - longint'(py[9:0])) * dy) >>> 10;
        w = m_mapw > 64 ? 64 : m_mapw;
        h = m_maph > 64 ? 64 : m_maph;
        lim = w * h + 1;
        for (longint n = 0; n < lim; n++)
        begin
            if (sx < sy)
            begin
                sx += dx;
                mx += stx;
                vert = 1'b1;
            end
            else
            begin
                sy += dy;
                my += sty;
                vert = 1'b0;
            end
            if (blocked(mx, my, w, h))
            begin
                wall_span = (vert ? sx - dx : sy - dy) >>> 8;
                if (wall_span < 1)
                    wall_span = 1;
                if (wall_span > 65535)
                    wall_span = 65535;
                r.hit = 1'b1;
                r.distance = wall_span[15:0];
                r.hit_x = mx[7:0];
                r.hit_y = my[7:0];
                r.vertical_wall = vert;
                break;
            end
        end
        return r;
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_PLANE_LENGTH: m_plane = val;
            CFG_SCREEN_WIDTH: m_screen = val[10:0];
            CFG_MAP_WIDTH:    m_mapw = val[6:0];
            default:          m_maph = val[6:0];
        endcase
    endtask

    // send one item; known, when set, overrides the predictor
    task automatic send_item(logic op, logic [5:0] cx, logic [5:0] cy, logic wl,
                             logic [15:0] px, logic [15:0] py, logic [9:0] hd,
                             logic [9:0] col, bit gaps, bit known = 0,
                             ray_hit_t known_val = '0);
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            cast_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        cast_ch.valid <= 1'b1;
        cast_ch.operation <= op;
        cast_ch.cell_x <= cx;
        cast_ch.cell_y <= cy;
        cast_ch.cell_wall <= wl;
        cast_ch.player_x <= px;
        cast_ch.player_y <= py;
        cast_ch.heading <= hd;
        cast_ch.column <= col;
        @(posedge clk);
        while (!cast_ch.ready)
            @(posedge clk);
        if (op == OP_WRITE)
            grid[{cy, cx}] = wl;
        else
            pending_hits.insert(pending_hits.size(),
                                known ? known_val : cast_ray(px, py, hd, col));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cast_ch.valid <= 1'b0;
        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // random cast from a small open box: most rays walk a few cells
    task automatic random_cast(bit gaps);
        logic [15:0] px, py;
        px = 16'($urandom);
        py = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
        begin
            px[15:10] = 6'($urandom_range(0, (m_mapw > 64 ? 64 : m_mapw) - 1));
            py[15:10] = 6'($urandom_range(0, (m_maph > 64 ? 64 : m_maph) - 1));
        end
        send_item(OP_CAST, 6'($urandom), 6'($urandom), 1'($urandom), px, py,
                  10'($urandom), 10'($urandom), gaps);
    endtask

    // result side
    initial
    begin
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                res_ch.ready <= 1'b0;
            else if (!sink_calm && $urandom_range(0, 9) == 0)
            begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                res_ch.ready <= 1'b1;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        ray_hit_t got, want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = '{res_ch.hit, res_ch.distance, res_ch.hit_x, res_ch.hit_y,
                    res_ch.vertical_wall};
            if (pending_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_hits.pop_front();
                casts_checked++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ray mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    // watchdog on cycles with no handshake; its limit covers the grid clear after reset
    always @(posedge clk)
    begin
        if ((cast_ch.valid && cast_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 40000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    typedef struct {
        logic op; logic [5:0] cx, cy; logic wl;
        logic [15:0] px, py; logic [9:0] hd, col;
        bit known; ray_hit_t val;
    } stim_row_t;

    stim_row_t rows [$];

    initial
    begin
        cfg_we = 1'b0;
        cfg_index = CFG_PLANE_LENGTH;
        cfg_data = '0;
        cast_ch.valid = 1'b0;
        cast_ch.operation = OP_WRITE;
        cast_ch.cell_x = '0;
        cast_ch.cell_y = '0;
        cast_ch.cell_wall = 1'b0;
        cast_ch.player_x = '0;
        cast_ch.player_y = '0;
        cast_ch.heading = '0;
        cast_ch.column = '0;
        hold_off = 1'b0;
        sink_calm = 1'b0;
        mismatches = 0;
        casts_checked = 0;
        idle_cycles = 0;
        foreach (grid[i]) grid[i] = 1'b0;
        m_plane = PLANE_LENGTH_RST;
        m_screen = SCREEN_WIDTH_RST;
        m_mapw = MAP_WIDTH_RST;
        m_maph = MAP_HEIGHT_RST;
        rst_n = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty map, walls, extremes
        rows = '{
            '{OP_CAST, 0, 0, 0, 16'h8200, 16'h8200, 0, 160, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'hFFFF, 16'hFFFF, 1023, 1023, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'h0000, 16'h0000, 512, 0, 0, '0},
            '{OP_WRITE, 33, 34, 1, 0, 0, 0, 0, 0, '0},
            '{OP_WRITE, 63, 63, 1, 0, 0, 0, 0, 0, '0},
            '{OP_WRITE, 0, 0, 1, 0, 0, 0, 0, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'h8600, 16'h8600, 256, 159, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'h8600, 16'h8600, 128, 319, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'h0600, 16'h0600, 640, 0, 0, '0},
            '{OP_CAST, 0, 0, 0, 16'hFC00, 16'h0400, 768, 700, 0, '0},
            '{OP_CAST, 63, 63, 0, 16'hFE00, 16'hFE00, 384, 1023, 0, '0},
            '{OP_WRITE, 33, 34, 0, 0, 0, 0, 0, 0, '0},
            '{OP_WRITE, 0, 0, 0, 0, 0, 0, 0, 0, '0}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].cx, rows[i].cy, rows[i].wl, rows[i].px,
                      rows[i].py, rows[i].hd, rows[i].col, 0, rows[i].known, rows[i].val);
        wait_idle();

        // one open cell map: the first step always hits an outside wall
        write_reg(CFG_MAP_WIDTH, 16'd1);
        write_reg(CFG_MAP_HEIGHT, 16'd1);
        write_reg(CFG_SCREEN_WIDTH, 16'd0);
        write_reg(CFG_PLANE_LENGTH, 16'hFFFF);
        send_item(OP_CAST, 0, 0, 0, 16'h0200, 16'h0200, 0, 0, 0);
        send_item(OP_CAST, 0, 0, 0, 16'h0000, 16'h0000, 300, 5, 0);
        wait_idle();
        // zero width map: every cell is a wall, straight ray along y hits half a cell away
        write_reg(CFG_MAP_WIDTH, 16'd0);
        send_item(OP_CAST, 0, 0, 0, 16'h0200, 16'h0200, 0, 0, 0, 1,
                  '{1'b1, 16'd128, 8'sd0, 8'sd1, 1'b0});
        wait_idle();
        write_reg(CFG_MAP_WIDTH, 16'h7F);
        write_reg(CFG_MAP_HEIGHT, 16'h7F);
        write_reg(CFG_SCREEN_WIDTH, 16'h7FF);
        write_reg(CFG_PLANE_LENGTH, 16'd0);
        send_item(OP_CAST, 0, 0, 0, 16'h1000, 16'h1000, 100, 1023, 0);
        wait_idle();

        // random phases over several settings, walls sprinkled
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_MAP_WIDTH, 16'($urandom_range(1, 24)));
            write_reg(CFG_MAP_HEIGHT, 16'($urandom_range(1, 24)));
            write_reg(CFG_SCREEN_WIDTH, 16'($urandom_range(1, 1024)));
            write_reg(CFG_PLANE_LENGTH, 16'($urandom));
            if (ph == 2)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(negedge clk);
                        hold_off = 1'b0;
                    end
                join_none
            if (ph == 5)
                sink_calm = 1'b1;
            for (int k = 0; k < 250; k++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_item(OP_WRITE, 6'($urandom), 6'($urandom),
                              $urandom_range(0, 4) == 0, 16'($urandom), 16'($urandom),
                              10'($urandom), 10'($urandom), ph != 5);
                else
                    random_cast(ph != 5);
            end
            wait_idle();
        end

        $display("covered %0d checked rays over six random map settings and directed edges",
                 casts_checked);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
